// ===== rtl/core/bspq_pkg.sv =====
// ----------------------------------------------------------------------------
// bspq_pkg: shared types and constants for the bounded sorted priority queue
// Holds the queue depth, the entry layout, the controller states and the
// ordering function used by the insertion cells.
// ----------------------------------------------------------------------------
package bspq_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int HDL_W   = 16;
  localparam int PRI_W   = 8;
  localparam int ARR_W   = 32;
  localparam int OCC_W   = 5;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic [HDL_W-1:0] handle;
    logic [PRI_W-1:0] priority_val;
    logic [ARR_W-1:0] arrival;
  } entry_t;

  typedef enum logic {
    CTL_IDLE,
    CTL_HOLD
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic push_en;
    logic pop_en;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

  // True if entry a must be served strictly after entry b.
  function automatic logic goes_after(entry_t a, entry_t b);
    logic res;
    if (a.priority_val != b.priority_val) begin
      res = (a.priority_val > b.priority_val);
    end else begin
      res = (a.arrival > b.arrival);
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/bspq_if.sv =====
// ----------------------------------------------------------------------------
// bspq_if: channel interfaces of the bounded sorted priority queue
// One interface for the operation channel and one for the result channel,
// each with valid/ready and its payload.
// ----------------------------------------------------------------------------
interface bspq_in_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [bspq_pkg::HDL_W-1:0] item_handle;
  logic [bspq_pkg::PRI_W-1:0] item_priority;
  logic [bspq_pkg::ARR_W-1:0] item_arrival;

  modport source (output valid, operation, item_handle, item_priority, item_arrival,
                  input ready);
  modport sink   (input valid, operation, item_handle, item_priority, item_arrival,
                  output ready);
endinterface

interface bspq_out_if;
  logic                      valid;
  logic                      ready;
  logic                      push_accepted;
  logic                      head_valid;
  logic [bspq_pkg::HDL_W-1:0] head_handle;
  logic [bspq_pkg::PRI_W-1:0] head_priority;
  logic [bspq_pkg::ARR_W-1:0] head_arrival;
  logic [bspq_pkg::OCC_W-1:0] occupancy;

  modport source (output valid, push_accepted, head_valid, head_handle, head_priority,
                         head_arrival, occupancy,
                  input ready);
  modport sink   (input valid, push_accepted, head_valid, head_handle, head_priority,
                        head_arrival, occupancy,
                  output ready);
endinterface

// ===== rtl/core/bspq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bspq_ctrl: handshake controller of the bounded sorted priority queue
// Tracks whether a result is pending and turns accepted items into push and
// pop commands for the datapath.
// ----------------------------------------------------------------------------
module bspq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_op,
  input  logic                 out_ready,
  input  bspq_pkg::dp_stat_t   stat,
  output logic                 in_ready,
  output logic                 out_valid,
  output bspq_pkg::dp_cmd_t    cmd
);

  bspq_pkg::ctl_state_t state_r, state_nxt;
  logic accept;

  // A new item may enter as soon as the pending result leaves in the same cycle.
  assign in_ready = (state_r == bspq_pkg::CTL_IDLE) || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bspq_pkg::CTL_IDLE: begin
        if (accept) state_nxt = bspq_pkg::CTL_HOLD;
      end
      bspq_pkg::CTL_HOLD: begin
        if (accept) begin
          state_nxt = bspq_pkg::CTL_HOLD;
        end else if (out_ready) begin
          state_nxt = bspq_pkg::CTL_IDLE;
        end
      end
      default: state_nxt = bspq_pkg::CTL_IDLE;
    endcase
  end

  always_comb begin
    out_valid   = 1'b0;
    cmd.accept  = accept;
    cmd.push_en = 1'b0;
    cmd.pop_en  = 1'b0;
    case (state_r)
      bspq_pkg::CTL_IDLE: out_valid = 1'b0;
      bspq_pkg::CTL_HOLD: out_valid = 1'b1;
      default:            out_valid = 1'b0;
    endcase
    if (accept) begin
      cmd.push_en = (in_op == bspq_pkg::OP_PUSH) && !stat.full;
      cmd.pop_en  = (in_op == bspq_pkg::OP_POP) && !stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bspq_pkg::CTL_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/bspq_dp.sv =====
// ----------------------------------------------------------------------------
// bspq_dp: sorted entry cells of the bounded sorted priority queue
// A row of cells, each comparing its entry with the pushed one; a push shifts
// the tail down by one from the insertion point, a pop shifts all cells up.
// ----------------------------------------------------------------------------
module bspq_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bspq_pkg::dp_cmd_t          cmd,
  input  bspq_pkg::entry_t           new_entry,
  output bspq_pkg::dp_stat_t         stat,
  output logic                       push_accepted,
  output logic                       head_valid,
  output bspq_pkg::entry_t           head_entry,
  output logic [bspq_pkg::OCC_W-1:0] occupancy
);

  localparam int DEPTH = bspq_pkg::DEPTH;
  localparam int CNT_W = bspq_pkg::CNT_W;

  bspq_pkg::entry_t       cells_r   [DEPTH];
  bspq_pkg::entry_t       cells_nxt [DEPTH];
  logic [DEPTH-1:0]       ins;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   acc_r;

  genvar k;
  generate
    for (k = 0; k < DEPTH; k++) begin : g_cell
      // Cells past the fill level count as insertion points, so the flags
      // rise once along the row and the first raised flag marks the slot.
      assign ins[k] = (CNT_W'(k) < count_r) ?
                      bspq_pkg::goes_after(cells_r[k], new_entry) : 1'b1;

      always_comb begin
        cells_nxt[k] = cells_r[k];
        if (cmd.push_en && ins[k]) begin
          if (k == 0) begin
            cells_nxt[k] = new_entry;
          end else begin
            cells_nxt[k] = ins[(k == 0) ? 0 : k-1] ? cells_r[(k == 0) ? 0 : k-1]
                                                 : new_entry;
          end
        end else if (cmd.pop_en && (k < DEPTH-1)) begin
          cells_nxt[k] = cells_r[(k < DEPTH-1) ? k+1 : k];
        end
      end

      always_ff @(posedge clk) begin
        cells_r[k] <= cells_nxt[k];
      end
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (cmd.push_en) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      acc_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.accept) acc_r <= cmd.push_en;
    end
  end

  assign stat.full     = (count_r == CNT_W'(DEPTH));
  assign stat.empty    = (count_r == '0);
  assign push_accepted = acc_r;
  assign head_valid    = !stat.empty;
  assign head_entry    = stat.empty ? '0 : cells_r[0];
  assign occupancy     = bspq_pkg::OCC_W'(count_r);

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_en |=> count_r == CNT_W'($past(count_r) + 1'b1))
    else $error("push did not add one entry");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_en |=> count_r == CNT_W'($past(count_r) - 1'b1))
    else $error("pop did not remove one entry");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_en |-> !stat.full && !cmd.pop_en)
    else $error("push command issued on a full queue or with a pop");

  a_front_order: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> !bspq_pkg::goes_after(cells_r[0], cells_r[1]))
    else $error("front entries out of service order");
`endif

endmodule

// ===== rtl/core/bounded_sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// bounded_sorted_priority_queue: fixed-capacity priority queue in sorted order
// Pushes insert by priority, then arrival, then insertion order; pops remove
// the front entry. Every item returns one result with the queue's front entry.
//
//   Channel    Dir  Handshake         Payload
//   in_chan    in   valid / ready     operation, item_handle/priority/arrival
//   out_chan   out  valid / ready     push_accepted, head_*, occupancy
//
// One item per cycle while results are taken: each cell compares with the
// pushed entry in parallel and the whole row shifts at once, so the result
// register is the only stage. The result appears the cycle after the item is
// accepted. A new item is taken while a result waits, provided that result
// leaves in the same cycle; a stalled result holds the input off.
// Reset (rst_n low, synchronous) empties the queue; there is no clearing pass.
// ----------------------------------------------------------------------------
module bounded_sorted_priority_queue (
  input  logic       clk,
  input  logic       rst_n,
  bspq_in_if.sink    in_chan,
  bspq_out_if.source out_chan
);

  bspq_pkg::dp_cmd_t  cmd;
  bspq_pkg::dp_stat_t stat;
  bspq_pkg::entry_t   new_entry;
  bspq_pkg::entry_t   head_entry;

  assign new_entry.handle       = in_chan.item_handle;
  assign new_entry.priority_val = in_chan.item_priority;
  assign new_entry.arrival      = in_chan.item_arrival;

  bspq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_op     (in_chan.operation),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .cmd       (cmd)
  );

  bspq_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .new_entry     (new_entry),
    .stat          (stat),
    .push_accepted (out_chan.push_accepted),
    .head_valid    (out_chan.head_valid),
    .head_entry    (head_entry),
    .occupancy     (out_chan.occupancy)
  );

  assign out_chan.head_handle   = head_entry.handle;
  assign out_chan.head_priority = head_entry.priority_val;
  assign out_chan.head_arrival  = head_entry.arrival;

endmodule
